// ===== sv/hnt_pkg.sv =====
// Package for the hash-noise terrain texel generator.
// Hash constants, seed constants, style word layout and style reset values.
// No dependencies.
`default_nettype none

package hnt_pkg;

  // Style word and configuration port
  localparam int unsigned STYLE_W   = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MAX_LAYERS = 4;

  // Byte lanes inside a style word
  localparam int unsigned BYTE_RED   = 0;
  localparam int unsigned BYTE_GREEN = 1;
  localparam int unsigned BYTE_BLUE  = 2;
  localparam int unsigned BYTE_GRAIN = 3;
  localparam int unsigned BYTE_ROUGH = 4;
  localparam int unsigned BYTE_AMP   = 5;

  // Multiply-xor hash
  localparam logic [31:0] HASH_X = 32'd374761393;
  localparam logic [31:0] HASH_Y = 32'd668265263;
  localparam logic [31:0] HASH_S = 32'd2246822519;
  localparam logic [31:0] HASH_M = 32'd1274126177;

  // Hash coordinate and seed widths (coordinate is -1..256, signed)
  localparam int unsigned COORD_W = 10;
  localparam int unsigned SEED_W  = 10;
  localparam int unsigned H24_W   = 24;

  // Per-layer seeds: color = layer*101+7, normal = layer*211+31, rough = normal+9
  localparam logic [SEED_W-1:0] CSEED_MUL = 10'd101;
  localparam logic [SEED_W-1:0] CSEED_ADD = 10'd7;
  localparam logic [SEED_W-1:0] NSEED_MUL = 10'd211;
  localparam logic [SEED_W-1:0] NSEED_ADD = 10'd31;
  localparam logic [SEED_W-1:0] RSEED_ADD = 10'd9;

  // Roughness variation span
  localparam logic [7:0] ROUGH_SPAN = 8'd40;

  // Style words after reset: grass, dirt, rock, snow
  localparam logic [STYLE_W-1:0] STYLE_RESET [MAX_LAYERS] = '{
    48'd38242764959109,
    48'd38264174191283,
    48'd66701289105837,
    48'd13709719894004
  };

endpackage

`default_nettype wire

// ===== sv/hnt_if.sv =====
// Valid/ready channel interfaces of the terrain texel generator.
// Input channel carries a texel coordinate and layer; output carries both texels.
// No dependencies.
`default_nettype none

interface hnt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [1:0] layer;

  modport source (output valid, pixel_x, pixel_y, layer, input ready);
  modport sink   (input valid, pixel_x, pixel_y, layer, output ready);
endinterface

interface hnt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_red;
  logic [7:0] base_green;
  logic [7:0] base_blue;
  logic [7:0] normal_x;
  logic [7:0] normal_y;
  logic [7:0] roughness;

  modport source (output valid, base_red, base_green, base_blue, normal_x, normal_y,
                  roughness, input ready);
  modport sink   (input valid, base_red, base_green, base_blue, normal_x, normal_y,
                  roughness, output ready);
endinterface

`default_nettype wire

// ===== sv/hnt_hash.sv =====
// One lane of the multiply-xor integer hash, three register stages deep.
// Depends on hnt_pkg for the hash constants and widths.
`default_nettype none

module hnt_hash (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [hnt_pkg::COORD_W-1:0]   x_i,
  input  wire logic [hnt_pkg::COORD_W-1:0]   y_i,
  input  wire logic [hnt_pkg::SEED_W-1:0]    seed_i,
  output logic      [hnt_pkg::H24_W-1:0]     h24_o
);
  import hnt_pkg::*;

  logic [31:0] x_ext, y_ext, s_ext;
  logic [31:0] xa_q, yb_q, sc_q;
  logic [31:0] sum, mix_d, mix_q;
  logic [31:0] mul_q;

  // Coordinates are signed (minus one wraps to all ones), seed is unsigned
  assign x_ext = {{(32-COORD_W){x_i[COORD_W-1]}}, x_i};
  assign y_ext = {{(32-COORD_W){y_i[COORD_W-1]}}, y_i};
  assign s_ext = {{(32-SEED_W){1'b0}}, seed_i};

  // Stage 1: constant products, modulo 2^32
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q <= x_ext * HASH_X;
      yb_q <= y_ext * HASH_Y;
      sc_q <= s_ext * HASH_S;
    end
  end

  // Stage 2: sum and first xor-shift
  assign sum   = xa_q + yb_q + sc_q;
  assign mix_d = sum ^ (sum >> 13);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q <= mix_d;
    end
  end

  // Stage 3: final multiply
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_q <= mix_q * HASH_M;
    end
  end

  // Second xor-shift, keep the low 24 bits
  assign h24_o = mul_q[H24_W-1:0] ^ {8'd0, mul_q[31:16]};

endmodule

`default_nettype wire

// ===== sv/hash_noise_terrain_texel.sv =====
// Hash-noise terrain texel generator: top level with style registers and pipeline.
// Depends on hnt_pkg, hnt_if (hnt_in_if, hnt_out_if) and hnt_hash.
//
//   channel   dir  payload                                          handshake
//   in_if     in   pixel_x, pixel_y, layer                          valid/ready
//   out_if    out  base_red/green/blue, normal_x/y, roughness       valid/ready
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (style words)    write enable
//
// Five register stages: three in the hash lanes, one for the scale products,
// one output register. One item per cycle while out_if is not stalled. The
// whole pipeline holds while a finished item waits on out_if.ready, so
// in_if.ready follows that stall. Reset clears the valid bits and loads the
// default style words.
`default_nettype none

module hash_noise_terrain_texel #(
  parameter int unsigned LAYER_COUNT = hnt_pkg::MAX_LAYERS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  hnt_in_if.sink                             in_if,
  hnt_out_if.source                          out_if,
  input  wire logic                          cfg_we_i,
  input  wire logic [hnt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [hnt_pkg::STYLE_W-1:0]   cfg_data_i
);
  import hnt_pkg::*;

  localparam int unsigned LAYER_IDX_W = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int unsigned NLANES = 6;
  localparam int unsigned PROD_W = 34;

  // Lane order
  localparam int unsigned L_COLOR = 0;
  localparam int unsigned L_XP    = 1;
  localparam int unsigned L_XM    = 2;
  localparam int unsigned L_YP    = 3;
  localparam int unsigned L_YM    = 4;
  localparam int unsigned L_ROUGH = 5;

  // ---------------------------------------------------------------------------
  // Pipeline control
  logic       advance;
  logic [3:0] v_q;
  logic       out_valid_q;

  assign advance     = !out_valid_q || out_if.ready;
  assign in_if.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v_q         <= {v_q[2:0], in_if.valid};
      out_valid_q <= v_q[3];
    end
  end

  // ---------------------------------------------------------------------------
  // Style registers: the user must write them only while idle; the block does not enforce it
  logic [STYLE_W-1:0] style_q [LAYER_COUNT];

  for (genvar g = 0; g < LAYER_COUNT; g++) begin : g_style
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        style_q[g] <= STYLE_RESET[g];
      end else if (cfg_we_i && (32'(cfg_idx_i) == g)) begin
        style_q[g] <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Layer select and seeds
  logic [1:0]             layer_sat;
  logic [LAYER_IDX_W-1:0] layer_idx;
  logic [SEED_W-1:0]      cseed, nseed, rseed;

  assign layer_sat = (32'(in_if.layer) >= LAYER_COUNT) ? 2'(LAYER_COUNT - 1) : in_if.layer;
  assign layer_idx = LAYER_IDX_W'(layer_sat);
  assign cseed     = SEED_W'(layer_sat) * CSEED_MUL + CSEED_ADD;
  assign nseed     = SEED_W'(layer_sat) * NSEED_MUL + NSEED_ADD;
  assign rseed     = nseed + RSEED_ADD;

  // Style word travels beside the hash lanes
  logic [STYLE_W-1:0] sty_q [4];

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sty_q[0] <= style_q[layer_idx];
      sty_q[1] <= sty_q[0];
      sty_q[2] <= sty_q[1];
      sty_q[3] <= sty_q[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Hash lanes: center, four neighbors, roughness
  logic [COORD_W-1:0] xc, xp, xm, yc, yp, ym;
  logic [COORD_W-1:0] lane_x [NLANES];
  logic [COORD_W-1:0] lane_y [NLANES];
  logic [SEED_W-1:0]  lane_s [NLANES];
  logic [H24_W-1:0]   lane_h [NLANES];

  assign xc = COORD_W'(in_if.pixel_x);
  assign yc = COORD_W'(in_if.pixel_y);
  assign xp = xc + 1'b1;
  assign xm = xc - 1'b1;
  assign yp = yc + 1'b1;
  assign ym = yc - 1'b1;

  always_comb begin
    lane_x[L_COLOR] = xc; lane_y[L_COLOR] = yc; lane_s[L_COLOR] = cseed;
    lane_x[L_XP]    = xp; lane_y[L_XP]    = yc; lane_s[L_XP]    = nseed;
    lane_x[L_XM]    = xm; lane_y[L_XM]    = yc; lane_s[L_XM]    = nseed;
    lane_x[L_YP]    = xc; lane_y[L_YP]    = yp; lane_s[L_YP]    = nseed;
    lane_x[L_YM]    = xc; lane_y[L_YM]    = ym; lane_s[L_YM]    = nseed;
    lane_x[L_ROUGH] = xc; lane_y[L_ROUGH] = yc; lane_s[L_ROUGH] = rseed;
  end

  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    hnt_hash u_hash (
      .clk_i  (clk_i),
      .en_i   (advance),
      .x_i    (lane_x[l]),
      .y_i    (lane_y[l]),
      .seed_i (lane_s[l]),
      .h24_o  (lane_h[l])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 4: center offsets, differences and scale products
  logic signed [H24_W:0]   c_col, c_rgh, diff_x, diff_y;
  logic signed [PROD_W-1:0] pd_d, px_d, py_d, pr_d;
  logic signed [PROD_W-1:0] pd_q, px_q, py_q, pr_q;
  logic [7:0]               grain, amp;

  assign grain  = sty_q[2][8*BYTE_GRAIN +: 8];
  assign amp    = sty_q[2][8*BYTE_AMP +: 8];
  assign c_col  = $signed({1'b0, lane_h[L_COLOR]}) - $signed(25'h0800000);
  assign c_rgh  = $signed({1'b0, lane_h[L_ROUGH]}) - $signed(25'h0800000);
  assign diff_x = $signed({1'b0, lane_h[L_XP]}) - $signed({1'b0, lane_h[L_XM]});
  assign diff_y = $signed({1'b0, lane_h[L_YP]}) - $signed({1'b0, lane_h[L_YM]});
  assign pd_d   = c_col * $signed({1'b0, grain});
  assign px_d   = diff_x * $signed({1'b0, amp});
  assign py_d   = diff_y * $signed({1'b0, amp});
  assign pr_d   = c_rgh * $signed({1'b0, ROUGH_SPAN});

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pd_q <= pd_d;
      px_q <= px_d;
      py_q <= py_d;
      pr_q <= pr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: truncating shifts, offsets, clamp
  function automatic logic signed [PROD_W-1:0] trunc_shr(
    input logic signed [PROD_W-1:0] p,
    input int unsigned              k
  );
    logic signed [PROD_W-1:0] bias;
    bias = p[PROD_W-1] ? ((PROD_W'(1) << k) - PROD_W'(1)) : '0;
    return (p + bias) >>> k;
  endfunction

  function automatic logic [7:0] sat8(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 11'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  logic signed [PROD_W-1:0] d_full, dx_full, dy_full, rv_full;
  logic signed [10:0]       d_s, dx_s, dy_s, rv_s;
  logic [7:0] red_d, green_d, blue_d, nx_d, ny_d, rough_d;
  logic [7:0] red_q, green_q, blue_q, nx_q, ny_q, rough_q;

  assign d_full  = trunc_shr(pd_q, 23);
  assign dx_full = trunc_shr(px_q, 24);
  assign dy_full = trunc_shr(py_q, 24);
  assign rv_full = trunc_shr(pr_q, 24);
  assign d_s     = d_full[10:0];
  assign dx_s    = dx_full[10:0];
  assign dy_s    = dy_full[10:0];
  assign rv_s    = rv_full[10:0];

  assign red_d   = sat8($signed({3'b0, sty_q[3][8*BYTE_RED +: 8]}) + d_s);
  assign green_d = sat8($signed({3'b0, sty_q[3][8*BYTE_GREEN +: 8]}) + d_s);
  assign blue_d  = sat8($signed({3'b0, sty_q[3][8*BYTE_BLUE +: 8]}) + d_s);
  assign nx_d    = sat8(11'sd128 - dx_s);
  assign ny_d    = sat8(11'sd128 - dy_s);
  assign rough_d = sat8($signed({3'b0, sty_q[3][8*BYTE_ROUGH +: 8]}) + rv_s);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      rough_q <= rough_d;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.base_red   = red_q;
  assign out_if.base_green = green_q;
  assign out_if.base_blue  = blue_q;
  assign out_if.normal_x   = nx_q;
  assign out_if.normal_y   = ny_q;
  assign out_if.roughness  = rough_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while output stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> v_q[0])
    else $error("accepted item lost at stage one");

  a_last_stage_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && advance) |=> out_if.valid)
    else $error("item lost between product stage and output");

endmodule

`default_nettype wire

// ===== tb/sv/hnt_texel_checker.sv =====
`timescale 1ns / 100ps
// Checker for the terrain texel generator: watches both channels and the style
// write port, predicts each texel pair and compares it with the block's output.
// Depends on hnt_in_if and hnt_out_if.

module hnt_texel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  hnt_in_if           in_mon,
  hnt_out_if          out_mon,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          outstanding_o
);

  // Hash multipliers and fixed-point scales
  localparam logic [31:0] MUL_X = 32'd374761393;
  localparam logic [31:0] MUL_Y = 32'd668265263;
  localparam logic [31:0] MUL_S = 32'd2246822519;
  localparam logic [31:0] MUL_M = 32'd1274126177;
  localparam longint      HALF  = 64'sd8388608;    // 2^23
  localparam longint      ONE   = 64'sd16777216;   // 2^24
  localparam longint      ROUGH_SPAN = 64'sd40;
  localparam int          REPORT_MAX = 10;

  // Style words after reset: grass, dirt, rock, snow
  localparam logic [47:0] STYLE_DEFAULT [4] = '{
    48'd38242764959109, 48'd38264174191283, 48'd66701289105837, 48'd13709719894004
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] nrm_x;
    logic [7:0] nrm_y;
    logic [7:0] rough;
  } texel_t;

  logic [47:0] style_q [4];
  texel_t      pending_texels [$];
  texel_t      got_t;
  texel_t      want_t;
  int          mismatches;

  assign fail_cnt_o = mismatches;

  // 32-bit multiply-xor hash, low 24 bits kept
  function automatic logic [23:0] hash24(logic [31:0] x, logic [31:0] y, logic [31:0] seed);
    logic [31:0] h;
    h = x * MUL_X + y * MUL_Y + seed * MUL_S;
    h = (h ^ (h >> 13)) * MUL_M;
    h = h ^ (h >> 16);
    return h[23:0];
  endfunction

  function automatic logic [7:0] sat8(longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic longint style_byte(logic [47:0] w, int k);
    return longint'(w[8*k +: 8]);
  endfunction

  // Both texels for one coordinate and layer under the current style words
  function automatic texel_t predict_texel(logic [7:0] px, logic [7:0] py, logic [1:0] lyr);
    logic [47:0] w;
    logic [31:0] x, y, cseed, nseed;
    longint      grain, amp, d, dx, dy, rv;
    texel_t      t;
    w     = style_q[lyr];
    x     = {24'd0, px};
    y     = {24'd0, py};
    cseed = {30'd0, lyr} * 32'd101 + 32'd7;
    nseed = {30'd0, lyr} * 32'd211 + 32'd31;
    grain = style_byte(w, 3);
    amp   = style_byte(w, 5);
    // grain offset, truncated toward zero
    d  = ((longint'(hash24(x, y, cseed)) - HALF) * grain) / HALF;
    // central differences; x-1 and y-1 wrap at zero as 32-bit values
    dx = longint'(hash24(x + 32'd1, y, nseed)) - longint'(hash24(x - 32'd1, y, nseed));
    dy = longint'(hash24(x, y + 32'd1, nseed)) - longint'(hash24(x, y - 32'd1, nseed));
    dx = (dx * amp) / ONE;
    dy = (dy * amp) / ONE;
    rv = ((longint'(hash24(x, y, nseed + 32'd9)) - HALF) * ROUGH_SPAN) / ONE;
    t.red   = sat8(style_byte(w, 0) + d);
    t.green = sat8(style_byte(w, 1) + d);
    t.blue  = sat8(style_byte(w, 2) + d);
    t.nrm_x = sat8(128 - dx);
    t.nrm_y = sat8(128 - dy);
    t.rough = sat8(style_byte(w, 4) + rv);
    return t;
  endfunction

  // Predict on input accept, compare on output accept, mirror style writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) style_q[i] <= STYLE_DEFAULT[i];
      pending_texels.delete();
      outstanding_o <= 0;
      mismatches = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        pending_texels.push_back(predict_texel(in_mon.pixel_x, in_mon.pixel_y, in_mon.layer));
      if (out_mon.valid && out_mon.ready) begin
        got_t = {out_mon.base_red, out_mon.base_green, out_mon.base_blue,
                 out_mon.normal_x, out_mon.normal_y, out_mon.roughness};
        if (pending_texels.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: texel with no item pending: r%0d g%0d b%0d nx%0d ny%0d ro%0d",
                     $realtime, got_t.red, got_t.green, got_t.blue,
                     got_t.nrm_x, got_t.nrm_y, got_t.rough);
        end else begin
          want_t = pending_texels.pop_front();
          if (got_t !== want_t) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: texel mismatch want r%0d g%0d b%0d nx%0d ny%0d ro%0d, got r%0d g%0d b%0d nx%0d ny%0d ro%0d",
                       $realtime, want_t.red, want_t.green, want_t.blue, want_t.nrm_x,
                       want_t.nrm_y, want_t.rough, got_t.red, got_t.green, got_t.blue,
                       got_t.nrm_x, got_t.nrm_y, got_t.rough);
          end
        end
      end
      if (cfg_we_i) style_q[cfg_idx_i] <= cfg_data_i;
      outstanding_o <= outstanding_o + int'(in_mon.valid && in_mon.ready)
                                     - int'(out_mon.valid && out_mon.ready);
    end
  end

endmodule

// ===== tb/sv/tb_hash_noise_terrain_texel.sv =====
`timescale 1ns / 100ps
// Testbench top for hash_noise_terrain_texel: clock, reset, style programming,
// coordinate stimulus with random gaps and output stalls, final verdict.
// Depends on hnt_pkg, hnt_if, hash_noise_terrain_texel and hnt_texel_checker.

module tb_hash_noise_terrain_texel;

  typedef enum logic [1:0] {REG_GRASS, REG_DIRT, REG_ROCK, REG_SNOW} style_reg_e;

  localparam int          RANDOM_PER_PHASE = 130;
  localparam int          GAP_PCT          = 31;
  localparam logic [47:0] STYLE_ALL_ONES   = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] STYLE_ALL_ZERO   = 48'h0;
  // dark colors, no base roughness, full grain and bump: drives clamps low
  localparam logic [47:0] STYLE_LOW_CLAMP  = 48'hFF00_FF00_0000;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [hnt_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [hnt_pkg::STYLE_W-1:0]   cfg_data;
  logic                          gaps_on;
  int                            fail_cnt;
  int                            outstanding;

  hnt_in_if  in_ch ();
  hnt_out_if out_ch ();

  hash_noise_terrain_texel dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  hnt_texel_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_cnt_o    (fail_cnt),
    .outstanding_o (outstanding)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random stalls while gaps are on
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !gaps_on || ($urandom_range(99) >= GAP_PCT);
    end
  end

  // Hard limit on run time
  initial begin
    #5000000;
    $display("tb_hash_noise_terrain_texel NOT OK");
    $finish;
  end

  // One item; each idle cycle in front is drawn with the gap odds, so the
  // sender idles in about GAP_PCT percent of its cycles. Valid stays high after.
  task automatic send_texel(input logic [7:0] x, input logic [7:0] y, input logic [1:0] lyr);
    while (gaps_on && ($urandom_range(99) < GAP_PCT)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.pixel_x <= x;
    in_ch.pixel_y <= y;
    in_ch.layer   <= lyr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_texel(8'($urandom_range(255)), 8'($urandom_range(255)), 2'($urandom_range(3)));
  endtask

  // Hold off the sender until every predicted texel has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding > 0);
  endtask

  task automatic write_style(input style_reg_e idx, input logic [47:0] word);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= word;
    @(posedge clk);
  endtask

  task automatic load_styles(input logic [47:0] grass, input logic [47:0] dirt,
                             input logic [47:0] rock, input logic [47:0] snow);
    write_style(REG_GRASS, grass);
    write_style(REG_DIRT, dirt);
    write_style(REG_ROCK, rock);
    write_style(REG_SNOW, snow);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [47:0] random_style();
    return {16'($urandom), $urandom};
  endfunction

  // Main sequence
  initial begin
    rst_n         <= 1'b0;
    gaps_on       <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_GRASS;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.pixel_x <= '0;
    in_ch.pixel_y <= '0;
    in_ch.layer   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset styles: corners (wrap at zero, no wrap past 255) on every layer
    for (int l = 0; l < 4; l++) begin
      send_texel(8'd0, 8'd0, 2'(l));
      send_texel(8'd255, 8'd255, 2'(l));
      send_texel(8'd0, 8'd255, 2'(l));
      send_texel(8'd255, 8'd0, 2'(l));
    end
    send_texel(8'd1, 8'd1, REG_GRASS);
    send_texel(8'd254, 8'd254, REG_DIRT);
    send_texel(8'd128, 8'd127, REG_ROCK);
    send_texel(8'd85, 8'd170, REG_SNOW);
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // Everything at full scale: clamps high
    load_styles(STYLE_ALL_ONES, STYLE_ALL_ONES, STYLE_ALL_ONES, STYLE_ALL_ONES);
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // No grain, no bump, zero colors
    load_styles(STYLE_ALL_ZERO, STYLE_ALL_ZERO, STYLE_ALL_ZERO, STYLE_ALL_ZERO);
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // Clamps low, mixed with full scale on one layer
    load_styles(STYLE_LOW_CLAMP, STYLE_LOW_CLAMP, STYLE_ALL_ONES, STYLE_LOW_CLAMP);
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // Random styles, back-to-back traffic with no gaps or stalls
    gaps_on <= 1'b0;
    load_styles(random_style(), random_style(), random_style(), random_style());
    send_random(RANDOM_PER_PHASE);
    wait_drained();
    gaps_on <= 1'b1;

    load_styles(random_style(), random_style(), random_style(), random_style());
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // Back to the default styles
    load_styles(hnt_pkg::STYLE_RESET[0], hnt_pkg::STYLE_RESET[1],
                hnt_pkg::STYLE_RESET[2], hnt_pkg::STYLE_RESET[3]);
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // Pipeline is five stages deep; allow some slack before the verdict
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && outstanding == 0)
      $display("tb_hash_noise_terrain_texel OK");
    else
      $display("tb_hash_noise_terrain_texel NOT OK");
    $finish;
  end

endmodule
